/* src/rbud_pkg.sv */
// shared types, constants and helper functions for the range bit unpack decoder
// no dependencies, compiled first
package rbud_pkg;

    localparam int SYM_MAX_W = 8;
    localparam int LIMIT_W = 17;
    localparam logic [16:0] OUT_LIMIT_RESET = 17'd4096;
    localparam logic [16:0] OUT_LIMIT_MAX = 17'd65536;
    localparam int Q_DEPTH_DEFAULT = 4;

    localparam logic [1:0] PH_LOW    = 2'd0;
    localparam logic [1:0] PH_HIGH   = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [1:0] PH_ABSORB = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_ORDER  = 2'd1;
    localparam logic [1:0] ST_HEADER = 2'd2;

    // one entry of the front-to-back queue
    typedef struct packed {
        logic        unpack;  // 0: single result, 1: symbols from the bit buffer
        logic [7:0]  value;   // result value, or low value for unpack
        logic [16:0] run;
        logic [1:0]  status;
        logic [15:0] store;   // bit buffer, msb first
        logic [4:0]  count;   // valid bits in store
        logic [3:0]  width;   // symbol width
        logic [3:0]  nsym;    // symbols to emit
        logic        last;    // last flag for the final symbol
    } job_t;

    // least w in 1..8 with range >> w == 0
    function automatic logic [3:0] sym_width(input logic [7:0] range);
        logic [3:0] w;
        w = 4'd8;
        for (int k = 7; k >= 1; k--) begin
            if ((range >> k) == 8'd0) begin
                w = 4'(k);
            end
        end
        return w;
    endfunction

    // min(floor(c / w), 8) for c below 16 and w in 1..8
    function automatic logic [3:0] sym_count(input logic [4:0] c, input logic [3:0] w);
        logic [3:0] q;
        logic [7:0] prod;
        q = 4'd0;
        prod = 8'd0;
        for (int k = 1; k <= SYM_MAX_W; k++) begin
            prod = 8'(k) * {4'd0, w};
            if (prod <= {3'd0, c}) begin
                q = 4'(k);
            end
        end
        return q;
    endfunction

endpackage

/* src/rbud_fifo.sv */
// short job queue between the front and the back part
// depends on rbud_pkg for job_t
module rbud_fifo #(
    parameter int DEPTH = rbud_pkg::Q_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  rbud_pkg::job_t push_job,
    input  logic          pop,
    output rbud_pkg::job_t head_job,
    output logic          full,
    output logic          empty
);
    import rbud_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_job = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* src/rbud_front.sv */
// front part: takes input words, tracks the block header and bit buffer,
// and queues result jobs; depends on rbud_pkg
module rbud_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // [7:0] in_byte
    input  logic           s_tlast,   // block_end
    input  logic [16:0]    out_limit,
    input  logic           full,
    output logic           push,
    output rbud_pkg::job_t push_job
);
    import rbud_pkg::*;

    logic [1:0]  phase_reg,   phase_next;
    logic [7:0]  low_reg,     low_next;
    logic [3:0]  width_reg,   width_next;
    logic [15:0] store_reg,   store_next;
    logic [4:0]  cnt_reg,     cnt_next;
    logic [16:0] emitted_reg, emitted_next;

    logic        take;
    logic [16:0] limit_eff;
    logic [15:0] store_cat;
    logic [4:0]  cnt_cat;
    logic [3:0]  q;
    logic [16:0] remain;
    logic [3:0]  nsym;
    logic [7:0]  used_bits;
    logic [16:0] emitted_sum;
    logic        hit;

    assign s_tready = !full;
    assign take     = s_tvalid && s_tready;

    always_comb begin
        if (out_limit == '0) begin
            limit_eff = 17'd1;
        end else if (out_limit > OUT_LIMIT_MAX) begin
            limit_eff = OUT_LIMIT_MAX;
        end else begin
            limit_eff = out_limit;
        end
    end

    // bit buffer after appending this byte; at most 15 bits are held
    assign store_cat   = {store_reg[7:0], s_tdata};
    assign cnt_cat     = cnt_reg + 5'd8;
    assign q           = sym_count(cnt_cat, width_reg);
    assign remain      = limit_eff - emitted_reg;
    assign nsym        = (remain < {13'd0, q}) ? remain[3:0] : q;
    assign used_bits   = {4'd0, nsym} * {4'd0, width_reg};
    assign emitted_sum = emitted_reg + {13'd0, nsym};
    assign hit         = (emitted_sum >= limit_eff);

    always_comb begin
        phase_next   = phase_reg;
        low_next     = low_reg;
        width_next   = width_reg;
        store_next   = store_reg;
        cnt_next     = cnt_reg;
        emitted_next = emitted_reg;
        push         = 1'b0;
        push_job     = '0;
        push_job.last = 1'b1;
        if (take) begin
            case (phase_reg)
                PH_LOW: begin
                    low_next     = s_tdata;
                    store_next   = '0;
                    cnt_next     = '0;
                    emitted_next = '0;
                    width_next   = '0;
                    if (s_tlast) begin
                        push            = 1'b1;
                        push_job.status = ST_HEADER;
                    end else begin
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH: begin
                    if (s_tdata < low_reg) begin
                        push            = 1'b1;
                        push_job.status = ST_ORDER;
                        phase_next      = s_tlast ? PH_LOW : PH_ABSORB;
                    end else if (s_tdata == low_reg) begin
                        // fill: one result stands for the whole limit
                        push            = 1'b1;
                        push_job.value  = low_reg;
                        push_job.run    = limit_eff;
                        push_job.status = ST_OK;
                        phase_next      = s_tlast ? PH_LOW : PH_ABSORB;
                    end else if (s_tlast) begin
                        push            = 1'b1;
                        push_job.status = ST_HEADER;
                        phase_next      = PH_LOW;
                    end else begin
                        width_next = sym_width(s_tdata - low_reg);
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA: begin
                    if (emitted_reg >= limit_eff) begin
                        phase_next = s_tlast ? PH_LOW : PH_ABSORB;
                    end else begin
                        push            = 1'b1;
                        push_job.unpack = 1'b1;
                        push_job.value  = low_reg;
                        push_job.run    = 17'd1;
                        push_job.status = ST_OK;
                        push_job.store  = store_cat;
                        push_job.count  = cnt_cat;
                        push_job.width  = width_reg;
                        push_job.nsym   = nsym;
                        push_job.last   = s_tlast || hit;
                        store_next      = store_cat;
                        cnt_next        = cnt_cat - used_bits[4:0];
                        emitted_next    = emitted_sum;
                        if (s_tlast) begin
                            phase_next = PH_LOW;
                        end else if (hit) begin
                            phase_next = PH_ABSORB;
                        end
                    end
                end
                default: begin
                    if (s_tlast) begin
                        phase_next = PH_LOW;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_LOW;
            low_reg     <= '0;
            width_reg   <= '0;
            store_reg   <= '0;
            cnt_reg     <= '0;
            emitted_reg <= '0;
        end else begin
            phase_reg   <= phase_next;
            low_reg     <= low_next;
            width_reg   <= width_next;
            store_reg   <= store_next;
            cnt_reg     <= cnt_next;
            emitted_reg <= emitted_next;
        end
    end

    // between data bytes fewer bits than one symbol remain
    assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (width_reg != '0) && (cnt_reg < {1'b0, width_reg}))
        else $error("bit count not below symbol width in data phase");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_job.unpack) |-> (push_job.nsym != '0)
            && (used_bits <= {3'd0, push_job.count}))
        else $error("unpack job with no symbols or too few bits");

    assert property (@(posedge aclk) disable iff (!aresetn)
        emitted_reg <= OUT_LIMIT_MAX)
        else $error("emitted count beyond maximum limit");

endmodule

/* src/rbud_back.sv */
// back part: turns queued jobs into result words, one per cycle while m_tready is high
// and the queue holds a job, through an output register; depends on rbud_pkg
module rbud_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  rbud_pkg::job_t head_job,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [31:0]    m_tdata,   // [7:0] value, [24:8] run, rest zero
    output logic [1:0]     m_tuser,   // [1:0] status
    output logic           m_tlast    // last
);
    import rbud_pkg::*;

    logic        m_tvalid_reg;
    logic [7:0]  value_reg;
    logic [16:0] run_reg;
    logic [1:0]  status_reg;
    logic        last_reg;
    logic [3:0]  idx_reg;   // symbols already sent from the head job
    logic [4:0]  pos_reg;   // bits still unread in the head job

    logic        out_free;
    logic        fire;
    logic [4:0]  pos_cur;
    logic [4:0]  pos_new;
    logic        final_sym;
    logic [15:0] shifted;
    logic [7:0]  mask;
    logic [7:0]  sym;

    assign out_free  = !m_tvalid_reg || m_tready;
    assign fire      = !empty && out_free;
    assign pos_cur   = (idx_reg == '0) ? head_job.count : pos_reg;
    assign pos_new   = pos_cur - {1'b0, head_job.width};
    assign final_sym = ((idx_reg + 4'd1) == head_job.nsym);
    assign shifted   = head_job.store >> pos_new;
    assign mask      = 8'((9'd1 << head_job.width) - 9'd1);
    assign sym       = shifted[7:0] & mask;
    assign pop       = fire && (!head_job.unpack || final_sym);

    always_ff @(posedge aclk) begin
        if (fire) begin
            if (head_job.unpack) begin
                value_reg  <= sym + head_job.value;
                run_reg    <= 17'd1;
                status_reg <= ST_OK;
                last_reg   <= final_sym && head_job.last;
            end else begin
                value_reg  <= head_job.value;
                run_reg    <= head_job.run;
                status_reg <= head_job.status;
                last_reg   <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
            idx_reg      <= '0;
            pos_reg      <= '0;
        end else begin
            if (out_free) begin
                m_tvalid_reg <= fire;
            end
            if (fire) begin
                idx_reg <= pop ? '0 : idx_reg + 4'd1;
                pos_reg <= pos_new;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {7'd0, run_reg, value_reg};
    assign m_tuser  = status_reg;
    assign m_tlast  = last_reg;

    // a partly sent job stays at the head of the queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        (idx_reg != '0) |-> !empty && head_job.unpack && (idx_reg < head_job.nsym))
        else $error("symbol index without a matching unpack job");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && head_job.unpack) |-> (pos_cur >= {1'b0, head_job.width}))
        else $error("bit buffer underflow");

    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (idx_reg == '0))
        else $error("symbol index not cleared after job done");

endmodule

/* src/range_bit_unpack_decoder_unit.sv */
// Frame-of-reference bit unpacking decoder.
// Input: one compressed byte per word on s_tdata, s_tlast marks the block's
// final byte. The first byte is the low value, the second the high value;
// later bytes are unpacked msb first into symbols of the least width that
// covers high - low, each sent as symbol + low. High equal to low gives a
// single fill result whose run is the output limit.
// Output: m_tdata holds value and run, m_tuser the status (ok, high below
// low, header-only block), m_tlast the block's final result.
// Config: the user writes out_limit via cfg_data (reset 4096) only while the block is idle; nothing enforces it.
// Timing: the front takes one byte per cycle while the job queue has room;
// the back sends one result per cycle while m_tready is high; a data byte
// yields one result per symbol, up to eight at symbol width one. The first
// result of a byte passes through the job queue and then the output register.
// Reset: aresetn low for one edge returns to expecting a low byte and empties
// the queue and the output register.
// Stall: while m_tready is low the result holds, the queue fills and then
// s_tready drops until the back drains it.
// depends on rbud_pkg, rbud_front, rbud_fifo, rbud_back
module range_bit_unpack_decoder_unit #(
    parameter int Q_DEPTH = rbud_pkg::Q_DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // block_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] value, [24:8] run, rest zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast,   // last
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [16:0] cfg_data   // [16:0] out_limit
);
    import rbud_pkg::*;

    logic [16:0] out_limit_reg;
    logic        push;
    logic        pop;
    logic        full;
    logic        empty;
    job_t        push_job;
    job_t        head_job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_limit_reg <= OUT_LIMIT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            out_limit_reg <= cfg_data;
        end
    end

    rbud_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .out_limit (out_limit_reg),
        .full      (full),
        .push      (push),
        .push_job  (push_job)
    );

    rbud_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .full     (full),
        .empty    (empty)
    );

    rbud_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head_job (head_job),
        .empty    (empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
